// File: hdl/rps_pkg.sv
package rps_pkg;

  localparam int ROM_ROWS = 49;

  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_PAUSE   = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  localparam logic [1:0] CFG_HOME_DUTY = 2'd0;
  localparam logic [1:0] CFG_BRAKE_MS  = 2'd1;
  localparam logic [1:0] CFG_SETTLE_MS = 2'd2;

  localparam logic [4:0]  PAUSE_MAX = 5'h1F;
  localparam logic [10:0] GUARD_CAP = 11'd1000;

  typedef struct packed {
    logic [6:0]  duty;
    logic        dir;
    logic        has_pos;
    logic [7:0]  start_pos;
    logic [7:0]  finish_pos;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [2:0]  repeats;
  } step_row_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [9:0] elapsed_ms;
    logic       work_enable;
    logic       keep_at_init;
    logic       at_init_position;
    logic [7:0] position;
  } tick_item_t;

  typedef struct packed {
    logic [6:0] home_duty;
    logic [9:0] brake_ms;
    logic [9:0] settle_ms;
  } cfg_regs_t;

  typedef struct packed {
    logic       run;
    logic       direction;
    logic [6:0] duty;
    logic [5:0] step_index;
  } result_t;

  function automatic step_row_t mk_row(
    input logic [6:0]  d,
    input logic        dr,
    input logic        hp,
    input logic [7:0]  s,
    input logic [7:0]  f,
    input logic [15:0] on_t,
    input logic [15:0] off_t,
    input logic [2:0]  rep
  );
    step_row_t r;
    r.duty       = d;
    r.dir        = dr;
    r.has_pos    = hp;
    r.start_pos  = s;
    r.finish_pos = f;
    r.on_ms      = on_t;
    r.off_ms     = off_t;
    r.repeats    = rep;
    return r;
  endfunction

  // rows past the table read as a rest row
  function automatic step_row_t rom_row(input logic [5:0] idx);
    step_row_t r;
    case (idx)
      6'd0:  r = mk_row(7'd70,  1'b0, 1'b1, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1);
      6'd1:  r = mk_row(7'd0,   1'b0, 1'b0, 8'd0, 8'd0, 16'd0,     16'd1000, 3'd1);
      6'd2:  r = mk_row(7'd100, 1'b1, 1'b0, 8'd0, 8'd0, 16'd17000, 16'd500,  3'd1);
      6'd3:  r = mk_row(7'd90,  1'b0, 1'b1, 8'd3, 8'd5, 16'd7000,  16'd500,  3'd2);
      6'd4:  r = mk_row(7'd60,  1'b0, 1'b1, 8'd3, 8'd5, 16'd7000,  16'd500,  3'd3);
      6'd5:  r = mk_row(7'd100, 1'b0, 1'b0, 8'd0, 8'd0, 16'd10000, 16'd500,  3'd1);
      6'd6:  r = mk_row(7'd60,  1'b0, 1'b1, 8'd3, 8'd5, 16'd7000,  16'd500,  3'd2);
      6'd7:  r = mk_row(7'd70,  1'b0, 1'b1, 8'd5, 8'd7, 16'd7000,  16'd500,  3'd3);
      6'd8:  r = mk_row(7'd90,  1'b0, 1'b1, 8'd3, 8'd5, 16'd7000,  16'd500,  3'd2);
      6'd9:  r = mk_row(7'd100, 1'b1, 1'b0, 8'd0, 8'd0, 16'd15000, 16'd500,  3'd1);
      6'd10: r = mk_row(7'd60,  1'b0, 1'b1, 8'd3, 8'd5, 16'd7000,  16'd500,  3'd2);
      6'd11: r = mk_row(7'd70,  1'b0, 1'b1, 8'd1, 8'd3, 16'd7000,  16'd500,  3'd3);
      6'd12: r = mk_row(7'd90,  1'b0, 1'b1, 8'd3, 8'd5, 16'd7000,  16'd500,  3'd2);
      6'd13: r = mk_row(7'd100, 1'b1, 1'b0, 8'd0, 8'd0, 16'd15000, 16'd500,  3'd1);
      6'd14: r = mk_row(7'd70,  1'b0, 1'b1, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1);
      6'd15: r = mk_row(7'd0,   1'b0, 1'b0, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1);
      6'd16: r = mk_row(7'd60,  1'b0, 1'b1, 8'd3, 8'd5, 16'd5000,  16'd500,  3'd2);
      6'd17: r = mk_row(7'd80,  1'b0, 1'b1, 8'd3, 8'd5, 16'd5000,  16'd500,  3'd2);
      6'd18: r = mk_row(7'd100, 1'b0, 1'b1, 8'd3, 8'd5, 16'd5000,  16'd500,  3'd3);
      6'd19: r = mk_row(7'd70,  1'b0, 1'b1, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1);
      6'd20: r = mk_row(7'd0,   1'b0, 1'b0, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1);
      6'd21: r = mk_row(7'd100, 1'b0, 1'b1, 8'd3, 8'd5, 16'd5000,  16'd500,  3'd3);
      6'd22: r = mk_row(7'd80,  1'b0, 1'b1, 8'd3, 8'd5, 16'd5000,  16'd500,  3'd2);
      6'd23: r = mk_row(7'd60,  1'b0, 1'b1, 8'd3, 8'd5, 16'd5000,  16'd500,  3'd2);
      6'd24: r = mk_row(7'd70,  1'b0, 1'b1, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1);
      6'd25: r = mk_row(7'd0,   1'b0, 1'b0, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1);
      6'd26: r = mk_row(7'd70,  1'b1, 1'b0, 8'd0, 8'd0, 16'd15000, 16'd500,  3'd1);
      6'd27: r = mk_row(7'd60,  1'b0, 1'b1, 8'd5, 8'd7, 16'd7000,  16'd500,  3'd2);
      6'd28: r = mk_row(7'd80,  1'b0, 1'b1, 8'd5, 8'd7, 16'd7000,  16'd500,  3'd2);
      6'd29: r = mk_row(7'd100, 1'b0, 1'b1, 8'd5, 8'd7, 16'd7000,  16'd500,  3'd4);
      6'd30: r = mk_row(7'd70,  1'b0, 1'b1, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1);
      6'd31: r = mk_row(7'd0,   1'b0, 1'b0, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1);
      6'd32: r = mk_row(7'd70,  1'b1, 1'b0, 8'd0, 8'd0, 16'd15000, 16'd500,  3'd1);
      6'd33: r = mk_row(7'd60,  1'b0, 1'b1, 8'd1, 8'd3, 16'd7000,  16'd500,  3'd2);
      6'd34: r = mk_row(7'd80,  1'b0, 1'b1, 8'd1, 8'd3, 16'd7000,  16'd500,  3'd2);
      6'd35: r = mk_row(7'd100, 1'b0, 1'b1, 8'd1, 8'd3, 16'd7000,  16'd500,  3'd4);
      6'd36: r = mk_row(7'd70,  1'b0, 1'b1, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1);
      6'd37: r = mk_row(7'd0,   1'b0, 1'b0, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1);
      6'd38: r = mk_row(7'd55,  1'b0, 1'b0, 8'd0, 8'd0, 16'd15000, 16'd500,  3'd1);
      6'd39: r = mk_row(7'd100, 1'b0, 1'b1, 8'd3, 8'd5, 16'd5000,  16'd500,  3'd3);
      6'd40: r = mk_row(7'd90,  1'b0, 1'b0, 8'd0, 8'd0, 16'd10000, 16'd500,  3'd1);
      6'd41: r = mk_row(7'd100, 1'b0, 1'b1, 8'd3, 8'd5, 16'd5000,  16'd500,  3'd3);
      6'd42: r = mk_row(7'd55,  1'b1, 1'b0, 8'd0, 8'd0, 16'd15000, 16'd500,  3'd1);
      6'd43: r = mk_row(7'd100, 1'b0, 1'b1, 8'd3, 8'd5, 16'd5000,  16'd500,  3'd3);
      6'd44: r = mk_row(7'd90,  1'b1, 1'b0, 8'd0, 8'd0, 16'd10000, 16'd500,  3'd1);
      6'd45: r = mk_row(7'd100, 1'b0, 1'b1, 8'd3, 8'd5, 16'd5000,  16'd500,  3'd3);
      6'd46: r = mk_row(7'd70,  1'b0, 1'b1, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1);
      6'd47: r = mk_row(7'd0,   1'b0, 1'b0, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1);
      6'd48: r = mk_row(7'd0,   1'b0, 1'b0, 8'd0, 8'd0, 16'd0,     16'd1000, 3'd1);
      default: r = mk_row(7'd0, 1'b0, 1'b0, 8'd0, 8'd0, 16'd0,     16'd1000, 3'd1);
    endcase
    return r;
  endfunction

endpackage

// File: hdl/rps_core.sv
module rps_core
  import rps_pkg::*;
#(
  parameter int STEP_COUNT = 49
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  tick_item_t item,
  input  cfg_regs_t  cfg,
  output result_t    result
);

  logic [4:0]  pause_depth, pause_depth_next;
  logic [5:0]  step_number, step_number_next;
  logic [15:0] step_elapsed, step_elapsed_next;
  logic [2:0]  repeat_count, repeat_count_next;
  logic [1:0]  sweep_phase, sweep_phase_next;
  logic        last_want, last_want_next;
  logic [10:0] guard_elapsed, guard_elapsed_next;
  logic        held_run, held_run_next;
  logic        held_dir, held_dir_next;
  logic [6:0]  held_duty, held_duty_next;

  step_row_t   row;
  logic        want;
  logic [16:0] se_sum;
  logic [15:0] se_sat;
  logic [16:0] on_off;
  logic [2:0]  rep_tmp;
  logic [6:0]  step_inc;
  logic [10:0] guard_tmp;

  assign row      = rom_row(step_number);
  assign se_sum   = {1'b0, step_elapsed} + {7'd0, item.elapsed_ms};
  assign se_sat   = se_sum[16] ? 16'hFFFF : se_sum[15:0];
  assign on_off   = {1'b0, row.on_ms} + {1'b0, row.off_ms};
  assign step_inc = {1'b0, step_number} + 7'd1;

  always_comb begin
    pause_depth_next   = pause_depth;
    step_number_next   = step_number;
    step_elapsed_next  = step_elapsed;
    repeat_count_next  = repeat_count;
    sweep_phase_next   = sweep_phase;
    last_want_next     = last_want;
    guard_elapsed_next = guard_elapsed;
    held_run_next      = held_run;
    held_dir_next      = held_dir;
    held_duty_next     = held_duty;
    want               = row.dir;
    rep_tmp            = repeat_count;
    guard_tmp          = guard_elapsed;

    case (item.mode)
      MODE_PAUSE: begin
        if (pause_depth < PAUSE_MAX) pause_depth_next = pause_depth + 5'd1;
      end
      MODE_RELEASE: begin
        if (pause_depth != 5'd0) pause_depth_next = pause_depth - 5'd1;
      end
      MODE_TICK: begin
        if (pause_depth != 5'd0) begin
          held_run_next  = 1'b0;
          held_duty_next = 7'd0;
        end else if (item.keep_at_init) begin
          held_run_next  = item.at_init_position;
          held_duty_next = item.at_init_position ? cfg.home_duty : 7'd0;
        end else if (item.work_enable) begin
          held_run_next     = 1'b1;
          step_elapsed_next = se_sat;
          if (row.has_pos) begin
            held_duty_next = row.duty;
            case (sweep_phase)
              2'd0: begin
                if (item.position == row.finish_pos || se_sat >= row.on_ms)
                  sweep_phase_next = 2'd1;
              end
              2'd1: begin
                want = ~row.dir;
                if (item.position == row.start_pos || se_sat >= row.on_ms)
                  sweep_phase_next = 2'd2;
              end
              default: begin
                sweep_phase_next  = 2'd0;
                step_elapsed_next = 16'd0;
                rep_tmp           = repeat_count + 3'd1;
              end
            endcase
          end else begin
            if (se_sat < row.on_ms) begin
              held_duty_next = row.duty;
            end else if ({1'b0, se_sat} < on_off) begin
              held_duty_next = 7'd0;
            end else begin
              // timer wrap keeps the previous duty for this tick
              step_elapsed_next = 16'd0;
              rep_tmp           = repeat_count + 3'd1;
            end
          end
          repeat_count_next = rep_tmp;
          if (rep_tmp >= row.repeats) begin
            repeat_count_next = 3'd0;
            step_number_next  = (step_inc >= 7'(STEP_COUNT)) ? 6'd0 : step_inc[5:0];
          end

          // dead time: restart the guard timer on a change of wanted direction
          if (last_want != want) begin
            last_want_next = want;
            guard_tmp      = 11'd0;
          end
          if (guard_tmp < GUARD_CAP) guard_tmp = guard_tmp + {1'b0, item.elapsed_ms};
          guard_elapsed_next = guard_tmp;
          if (guard_tmp < {1'b0, cfg.brake_ms}) begin
            held_duty_next = 7'd0;
          end else if (guard_tmp < {1'b0, cfg.settle_ms}) begin
            held_duty_next = 7'd0;
            held_dir_next  = want;
          end
        end else begin
          sweep_phase_next  = 2'd0;
          step_number_next  = 6'd0;
          step_elapsed_next = 16'd0;
          repeat_count_next = 3'd0;
          held_run_next     = item.at_init_position;
          held_duty_next    = item.at_init_position ? cfg.home_duty : 7'd0;
          if (!item.at_init_position) held_dir_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pause_depth   <= 5'd0;
      step_number   <= 6'd0;
      step_elapsed  <= 16'd0;
      repeat_count  <= 3'd0;
      sweep_phase   <= 2'd0;
      last_want     <= 1'b0;
      guard_elapsed <= 11'd0;
      held_run      <= 1'b0;
      held_dir      <= 1'b0;
      held_duty     <= 7'd0;
    end else if (take) begin
      pause_depth   <= pause_depth_next;
      step_number   <= step_number_next;
      step_elapsed  <= step_elapsed_next;
      repeat_count  <= repeat_count_next;
      sweep_phase   <= sweep_phase_next;
      last_want     <= last_want_next;
      guard_elapsed <= guard_elapsed_next;
      held_run      <= held_run_next;
      held_dir      <= held_dir_next;
      held_duty     <= held_duty_next;
    end
  end

  assign result.run        = held_run_next;
  assign result.direction  = held_dir_next;
  assign result.duty       = held_duty_next;
  assign result.step_index = step_number_next;

endmodule

// File: hdl/roller_pattern_sequencer_with_deadtime.sv
// Channel   Handshake              Payload
// input     in_valid / in_stall    mode, elapsed_ms, work_enable, keep_at_init,
//                                  at_init_position, position
// output    out_valid / out_stall  run, direction, duty, step_index
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per cycle sustained while out_stall is low; a result passes through
// the input register, then the step logic into the result register.
// The step ROM read, timer compare and guard compare all sit in that one stage of step logic.
// Synchronous reset clears state and restores the register defaults (70, 100, 200).
// A stalled output holds its result; input stalls only while full behind a stalled output.
module roller_pattern_sequencer_with_deadtime
  import rps_pkg::*;
#(
  parameter int STEP_COUNT = 49
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [9:0] elapsed_ms,
  input  logic       work_enable,
  input  logic       keep_at_init,
  input  logic       at_init_position,
  input  logic [7:0] position,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       run,
  output logic       direction,
  output logic [6:0] duty,
  output logic [5:0] step_index,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);

  cfg_regs_t  cfg;
  tick_item_t in_item;
  logic       in_full;
  logic       advance;
  logic       take;
  result_t    result;
  result_t    out_reg;

  assign advance   = !out_valid || !out_stall;
  assign take      = in_full && advance;
  assign in_stall  = in_full && !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.home_duty <= 7'd70;
      cfg.brake_ms  <= 10'd100;
      cfg.settle_ms <= 10'd200;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HOME_DUTY: cfg.home_duty <= cfg_data[6:0];
        CFG_BRAKE_MS:  cfg.brake_ms  <= cfg_data;
        CFG_SETTLE_MS: cfg.settle_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (take) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item.mode             <= mode;
      in_item.elapsed_ms       <= elapsed_ms;
      in_item.work_enable      <= work_enable;
      in_item.keep_at_init     <= keep_at_init;
      in_item.at_init_position <= at_init_position;
      in_item.position         <= position;
    end
  end

  rps_core #(
    .STEP_COUNT(STEP_COUNT)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .item  (in_item),
    .cfg   (cfg),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_reg <= result;
  end

  assign run        = out_reg.run;
  assign direction  = out_reg.direction;
  assign duty       = out_reg.duty;
  assign step_index = out_reg.step_index;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rps_pkg::*;

  localparam int STEP_COUNT = 49;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_CAP = 100;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [6:0]  duty;
    logic        dir;
    logic        has_pos;
    logic [7:0]  start;
    logic [7:0]  fin;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [2:0]  reps;
  } pattern_step_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] mode = MODE_TICK;
  logic [9:0] elapsed_ms = '0;
  logic       work_enable = 1'b0;
  logic       keep_at_init = 1'b0;
  logic       at_init_position = 1'b0;
  logic [7:0] position = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       run;
  logic       direction;
  logic [6:0] duty;
  logic [5:0] step_index;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_HOME_DUTY;
  logic [9:0] cfg_data = '0;

  roller_pattern_sequencer_with_deadtime #(
    .STEP_COUNT(STEP_COUNT)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .elapsed_ms(elapsed_ms),
    .work_enable(work_enable),
    .keep_at_init(keep_at_init),
    .at_init_position(at_init_position),
    .position(position),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .run(run),
    .direction(direction),
    .duty(duty),
    .step_index(step_index),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // sequencer copy: registers and state at their reset values
  logic [6:0]  home_duty_r = 7'd70;
  logic [9:0]  brake_r = 10'd100;
  logic [9:0]  settle_r = 10'd200;
  logic [4:0]  pause_lvl = '0;
  logic [5:0]  step_num = '0;
  int unsigned step_ms = 0;
  logic [2:0]  rep_cnt = '0;
  logic [1:0]  sweep = '0;
  logic        want_prev = 1'b0;
  int unsigned guard_ms = 0;
  logic        d_run = 1'b0;
  logic        d_dir = 1'b0;
  logic [6:0]  d_duty = '0;

  tick_item_t tick_q[$];
  result_t    drive_q[$];
  tick_item_t cur_tick;
  bit         in_accepted = 1'b0;
  bit         quiet = 1'b0;
  int         errors = 0;
  int         cycle_cnt = 0;

  function automatic pattern_step_t pattern_row(input logic [5:0] idx);
    pattern_step_t r;
    case (idx)
      6'd0:  r = {7'd70,  1'b0, 1'b1, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1};
      6'd1:  r = {7'd0,   1'b0, 1'b0, 8'd0, 8'd0, 16'd0,     16'd1000, 3'd1};
      6'd2:  r = {7'd100, 1'b1, 1'b0, 8'd0, 8'd0, 16'd17000, 16'd500,  3'd1};
      6'd3:  r = {7'd90,  1'b0, 1'b1, 8'd3, 8'd5, 16'd7000,  16'd500,  3'd2};
      6'd4:  r = {7'd60,  1'b0, 1'b1, 8'd3, 8'd5, 16'd7000,  16'd500,  3'd3};
      6'd5:  r = {7'd100, 1'b0, 1'b0, 8'd0, 8'd0, 16'd10000, 16'd500,  3'd1};
      6'd6:  r = {7'd60,  1'b0, 1'b1, 8'd3, 8'd5, 16'd7000,  16'd500,  3'd2};
      6'd7:  r = {7'd70,  1'b0, 1'b1, 8'd5, 8'd7, 16'd7000,  16'd500,  3'd3};
      6'd8:  r = {7'd90,  1'b0, 1'b1, 8'd3, 8'd5, 16'd7000,  16'd500,  3'd2};
      6'd9:  r = {7'd100, 1'b1, 1'b0, 8'd0, 8'd0, 16'd15000, 16'd500,  3'd1};
      6'd10: r = {7'd60,  1'b0, 1'b1, 8'd3, 8'd5, 16'd7000,  16'd500,  3'd2};
      6'd11: r = {7'd70,  1'b0, 1'b1, 8'd1, 8'd3, 16'd7000,  16'd500,  3'd3};
      6'd12: r = {7'd90,  1'b0, 1'b1, 8'd3, 8'd5, 16'd7000,  16'd500,  3'd2};
      6'd13: r = {7'd100, 1'b1, 1'b0, 8'd0, 8'd0, 16'd15000, 16'd500,  3'd1};
      6'd14: r = {7'd70,  1'b0, 1'b1, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1};
      6'd15: r = {7'd0,   1'b0, 1'b0, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1};
      6'd16: r = {7'd60,  1'b0, 1'b1, 8'd3, 8'd5, 16'd5000,  16'd500,  3'd2};
      6'd17: r = {7'd80,  1'b0, 1'b1, 8'd3, 8'd5, 16'd5000,  16'd500,  3'd2};
      6'd18: r = {7'd100, 1'b0, 1'b1, 8'd3, 8'd5, 16'd5000,  16'd500,  3'd3};
      6'd19: r = {7'd70,  1'b0, 1'b1, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1};
      6'd20: r = {7'd0,   1'b0, 1'b0, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1};
      6'd21: r = {7'd100, 1'b0, 1'b1, 8'd3, 8'd5, 16'd5000,  16'd500,  3'd3};
      6'd22: r = {7'd80,  1'b0, 1'b1, 8'd3, 8'd5, 16'd5000,  16'd500,  3'd2};
      6'd23: r = {7'd60,  1'b0, 1'b1, 8'd3, 8'd5, 16'd5000,  16'd500,  3'd2};
      6'd24: r = {7'd70,  1'b0, 1'b1, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1};
      6'd25: r = {7'd0,   1'b0, 1'b0, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1};
      6'd26: r = {7'd70,  1'b1, 1'b0, 8'd0, 8'd0, 16'd15000, 16'd500,  3'd1};
      6'd27: r = {7'd60,  1'b0, 1'b1, 8'd5, 8'd7, 16'd7000,  16'd500,  3'd2};
      6'd28: r = {7'd80,  1'b0, 1'b1, 8'd5, 8'd7, 16'd7000,  16'd500,  3'd2};
      6'd29: r = {7'd100, 1'b0, 1'b1, 8'd5, 8'd7, 16'd7000,  16'd500,  3'd4};
      6'd30: r = {7'd70,  1'b0, 1'b1, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1};
      6'd31: r = {7'd0,   1'b0, 1'b0, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1};
      6'd32: r = {7'd70,  1'b1, 1'b0, 8'd0, 8'd0, 16'd15000, 16'd500,  3'd1};
      6'd33: r = {7'd60,  1'b0, 1'b1, 8'd1, 8'd3, 16'd7000,  16'd500,  3'd2};
      6'd34: r = {7'd80,  1'b0, 1'b1, 8'd1, 8'd3, 16'd7000,  16'd500,  3'd2};
      6'd35: r = {7'd100, 1'b0, 1'b1, 8'd1, 8'd3, 16'd7000,  16'd500,  3'd4};
      6'd36: r = {7'd70,  1'b0, 1'b1, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1};
      6'd37: r = {7'd0,   1'b0, 1'b0, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1};
      6'd38: r = {7'd55,  1'b0, 1'b0, 8'd0, 8'd0, 16'd15000, 16'd500,  3'd1};
      6'd39: r = {7'd100, 1'b0, 1'b1, 8'd3, 8'd5, 16'd5000,  16'd500,  3'd3};
      6'd40: r = {7'd90,  1'b0, 1'b0, 8'd0, 8'd0, 16'd10000, 16'd500,  3'd1};
      6'd41: r = {7'd100, 1'b0, 1'b1, 8'd3, 8'd5, 16'd5000,  16'd500,  3'd3};
      6'd42: r = {7'd55,  1'b1, 1'b0, 8'd0, 8'd0, 16'd15000, 16'd500,  3'd1};
      6'd43: r = {7'd100, 1'b0, 1'b1, 8'd3, 8'd5, 16'd5000,  16'd500,  3'd3};
      6'd44: r = {7'd90,  1'b1, 1'b0, 8'd0, 8'd0, 16'd10000, 16'd500,  3'd1};
      6'd45: r = {7'd100, 1'b0, 1'b1, 8'd3, 8'd5, 16'd5000,  16'd500,  3'd3};
      6'd46: r = {7'd70,  1'b0, 1'b1, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1};
      6'd47: r = {7'd0,   1'b0, 1'b0, 8'd0, 8'd0, 16'd5000,  16'd500,  3'd1};
      // rest row, also read for any step past the table
      default: r = {7'd0, 1'b0, 1'b0, 8'd0, 8'd0, 16'd0, 16'd1000, 3'd1};
    endcase
    return r;
  endfunction

  // advances the sequencer copy by one transaction, returns the drive it reports
  function automatic result_t next_drive(input tick_item_t it);
    pattern_step_t r;
    logic          want;
    result_t       res;
    case (it.mode)
      MODE_PAUSE: begin
        if (pause_lvl < PAUSE_MAX) pause_lvl = pause_lvl + 5'd1;
      end
      MODE_RELEASE: begin
        if (pause_lvl != 5'd0) pause_lvl = pause_lvl - 5'd1;
      end
      MODE_TICK: begin
        if (pause_lvl != 5'd0) begin
          d_run = 1'b0;
          d_duty = '0;
        end else if (it.keep_at_init) begin
          d_run = it.at_init_position;
          d_duty = it.at_init_position ? home_duty_r : 7'd0;
        end else if (it.work_enable) begin
          r = pattern_row(step_num);
          want = r.dir;
          d_run = 1'b1;
          step_ms = step_ms + it.elapsed_ms;
          if (step_ms > 32'hFFFF) step_ms = 32'hFFFF;
          if (r.has_pos) begin
            d_duty = r.duty;
            if (sweep == 2'd0) begin
              if (it.position == r.fin || step_ms >= r.on_ms) sweep = 2'd1;
            end else if (sweep == 2'd1) begin
              want = ~want;
              if (it.position == r.start || step_ms >= r.on_ms) sweep = 2'd2;
            end else begin
              sweep = 2'd0;
              step_ms = 0;
              rep_cnt = rep_cnt + 3'd1;
            end
          end else begin
            if (step_ms < r.on_ms) begin
              d_duty = r.duty;
            end else if (step_ms < 32'(r.on_ms) + 32'(r.off_ms)) begin
              d_duty = '0;
            end else begin
              // timer wrap: duty keeps last value
              step_ms = 0;
              rep_cnt = rep_cnt + 3'd1;
            end
          end
          if (rep_cnt >= r.reps) begin
            rep_cnt = '0;
            step_num = step_num + 6'd1;
            if (step_num >= STEP_COUNT) step_num = '0;
          end
          if (want_prev != want) begin
            want_prev = want;
            guard_ms = 0;
          end
          if (guard_ms < GUARD_CAP) guard_ms = guard_ms + it.elapsed_ms;
          if (guard_ms < brake_r) begin
            d_duty = '0;
          end else if (guard_ms < settle_r) begin
            d_duty = '0;
            d_dir = want;
          end
        end else begin
          sweep = '0;
          step_num = '0;
          step_ms = 0;
          rep_cnt = '0;
          d_run = it.at_init_position;
          d_duty = it.at_init_position ? home_duty_r : 7'd0;
          if (!it.at_init_position) d_dir = 1'b0;
        end
      end
      default: begin
      end
    endcase
    res.run = d_run;
    res.direction = d_dir;
    res.duty = d_duty;
    res.step_index = step_num;
    return res;
  endfunction

  function automatic tick_item_t make_tick(input logic [1:0] m, input logic [9:0] ms,
                                           input logic work, input logic keep,
                                           input logic away, input logic [7:0] pos);
    tick_item_t t;
    t.mode = m;
    t.elapsed_ms = ms;
    t.work_enable = work;
    t.keep_at_init = keep;
    t.at_init_position = away;
    t.position = pos;
    return t;
  endfunction

  function automatic logic [9:0] rand_ms();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return 10'($urandom_range(1000, 500));
    if (pick < 90) return 10'($urandom_range(499));
    return 10'($urandom_range(1023, 900));
  endfunction

  // positions near the sweep end points hit the start/finish compares often
  function automatic logic [7:0] rand_pos();
    if ($urandom_range(99) < 75) return 8'($urandom_range(8));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("ERROR cycle %0d: %s", cycle_cnt, msg);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_HOME_DUTY: home_duty_r = data[6:0];
      CFG_BRAKE_MS:  brake_r = data;
      CFG_SETTLE_MS: settle_r = data;
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle(input int extra);
    while (tick_q.size() != 0 || in_valid || drive_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic queue_random(input int n);
    int added, kind, len, depth, rel;
    logic keep;
    added = 0;
    while (added < n) begin
      kind = $urandom_range(99);
      if (kind < 74) begin
        len = $urandom_range(20, 1);
        repeat (len) tick_q.push_back(make_tick(MODE_TICK, rand_ms(), 1'b1, 1'b0,
                                                rand_bit(), rand_pos()));
        added += len;
      end else if (kind < 86) begin
        // nested pause; now and then deep enough to saturate
        depth = ($urandom_range(19) == 0) ? $urandom_range(34, 30) : $urandom_range(3, 1);
        len = $urandom_range(3);
        rel = ($urandom_range(9) == 0) ? depth - 1 : depth + $urandom_range(1);
        repeat (depth) tick_q.push_back(make_tick(MODE_PAUSE, rand_ms(), rand_bit(),
                                                  rand_bit(), rand_bit(), rand_pos()));
        repeat (len) tick_q.push_back(make_tick(MODE_TICK, rand_ms(), rand_bit(),
                                                rand_bit(), rand_bit(), rand_pos()));
        repeat (rel) tick_q.push_back(make_tick(MODE_RELEASE, rand_ms(), rand_bit(),
                                                rand_bit(), rand_bit(), rand_pos()));
        added += depth + len + rel;
      end else if (kind < 93) begin
        len = $urandom_range(6, 1);
        repeat (len) begin
          keep = rand_bit();
          tick_q.push_back(make_tick(MODE_TICK, rand_ms(), keep ? rand_bit() : 1'b0,
                                     keep, rand_bit(), rand_pos()));
        end
        added += len;
      end else begin
        tick_q.push_back(make_tick(2'($urandom_range(3)), 10'($urandom_range(1023)),
                                   rand_bit(), rand_bit(), rand_bit(),
                                   8'($urandom_range(255))));
        added++;
      end
    end
  endtask

  task automatic run_phase(input logic [6:0] hd, input logic [9:0] br,
                           input logic [9:0] st, input int n);
    write_reg(CFG_HOME_DUTY, {3'd0, hd});
    write_reg(CFG_BRAKE_MS, br);
    write_reg(CFG_SETTLE_MS, st);
    queue_random(n);
    wait_idle(6);
  endtask

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("roller_pattern_sequencer_with_deadtime test failed");
      $finish;
    end
  end

  // input side: predict at the accepting edge, present the next tick at the falling edge
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      drive_q.push_back(next_drive(cur_tick));
      in_accepted = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      in_accepted = 1'b0;
      if (tick_q.size() != 0 && (quiet || $urandom_range(99) >= 7)) begin
        cur_tick = tick_q.pop_front();
        mode <= cur_tick.mode;
        elapsed_ms <= cur_tick.elapsed_ms;
        work_enable <= cur_tick.work_enable;
        keep_at_init <= cur_tick.keep_at_init;
        at_init_position <= cur_tick.at_init_position;
        position <= cur_tick.position;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side
  always @(negedge clk) begin
    out_stall <= !rst && !quiet && ($urandom_range(99) < 7);
  end

  always @(posedge clk) begin
    result_t want_res;
    if (!rst && out_valid && !out_stall) begin
      if (drive_q.size() == 0) begin
        flag_error("result transaction with nothing expected");
      end else begin
        want_res = drive_q.pop_front();
        if (run !== want_res.run)
          flag_error($sformatf("run got %0d expected %0d", run, want_res.run));
        if (direction !== want_res.direction)
          flag_error($sformatf("direction got %0d expected %0d", direction,
                               want_res.direction));
        if (duty !== want_res.duty)
          flag_error($sformatf("duty got %0d expected %0d", duty, want_res.duty));
        if (step_index !== want_res.step_index)
          flag_error($sformatf("step_index got %0d expected %0d", step_index,
                               want_res.step_index));
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset register values
    tick_q.push_back(make_tick(MODE_TICK, 10'd0, 1'b0, 1'b0, 1'b0, 8'd0));
    tick_q.push_back(make_tick(MODE_TICK, 10'd0, 1'b0, 1'b0, 1'b1, 8'd255));
    tick_q.push_back(make_tick(MODE_TICK, 10'd1023, 1'b1, 1'b1, 1'b1, 8'd0));
    tick_q.push_back(make_tick(MODE_TICK, 10'd1000, 1'b1, 1'b1, 1'b0, 8'd0));
    // step 0 sweeps at position 0, step 1 wraps its timer with duty held
    tick_q.push_back(make_tick(MODE_TICK, 10'd1000, 1'b1, 1'b0, 1'b1, 8'd0));
    tick_q.push_back(make_tick(MODE_TICK, 10'd1000, 1'b1, 1'b0, 1'b1, 8'd0));
    tick_q.push_back(make_tick(MODE_TICK, 10'd0, 1'b1, 1'b0, 1'b1, 8'd0));
    tick_q.push_back(make_tick(MODE_TICK, 10'd1000, 1'b1, 1'b0, 1'b0, 8'd255));
    tick_q.push_back(make_tick(MODE_TICK, 10'd1023, 1'b1, 1'b0, 1'b1, 8'd255));
    tick_q.push_back(make_tick(MODE_TICK, 10'd1000, 1'b1, 1'b0, 1'b1, 8'd5));
    tick_q.push_back(make_tick(MODE_TICK, 10'd1, 1'b1, 1'b0, 1'b1, 8'd3));
    tick_q.push_back(make_tick(MODE_PAUSE, 10'd0, 1'b1, 1'b0, 1'b1, 8'd0));
    tick_q.push_back(make_tick(MODE_PAUSE, 10'd1023, 1'b0, 1'b1, 1'b0, 8'd255));
    tick_q.push_back(make_tick(MODE_TICK, 10'd1000, 1'b1, 1'b0, 1'b1, 8'd0));
    tick_q.push_back(make_tick(MODE_NONE, 10'd1000, 1'b1, 1'b0, 1'b1, 8'd0));
    tick_q.push_back(make_tick(MODE_RELEASE, 10'd0, 1'b1, 1'b0, 1'b1, 8'd0));
    tick_q.push_back(make_tick(MODE_RELEASE, 10'd0, 1'b1, 1'b0, 1'b1, 8'd0));
    tick_q.push_back(make_tick(MODE_RELEASE, 10'd0, 1'b1, 1'b0, 1'b1, 8'd0));
    tick_q.push_back(make_tick(MODE_TICK, 10'd1000, 1'b1, 1'b0, 1'b1, 8'd0));
    tick_q.push_back(make_tick(MODE_TICK, 10'd0, 1'b1, 1'b0, 1'b1, 8'd7));
    tick_q.push_back(make_tick(MODE_TICK, 10'd500, 1'b0, 1'b0, 1'b1, 8'd0));
    tick_q.push_back(make_tick(MODE_TICK, 10'd500, 1'b0, 1'b0, 1'b0, 8'd0));
    tick_q.push_back(make_tick(MODE_TICK, 10'd1000, 1'b1, 1'b0, 1'b1, 8'd255));
    wait_idle(6);

    run_phase(7'd100, 10'd0, 10'd0, 200);
    // brake not below settle: direction never latched by the guard
    write_reg(CFG_SPARE, 10'h3FF);
    run_phase(7'd0, 10'd1000, 10'd1000, 150);
    quiet = 1'b1;
    run_phase(7'($urandom_range(100)), 10'd500, 10'd100, 150);
    quiet = 1'b0;
    run_phase(7'd70, 10'd100, 10'd200, 150);
    run_phase(7'($urandom_range(100)), 10'($urandom_range(1000)),
              10'($urandom_range(1000)), 150);

    wait_idle(12);
    if (drive_q.size() != 0) flag_error("results still expected at end of run");
    if (errors == 0) begin
      $display("roller_pattern_sequencer_with_deadtime test passed");
    end else begin
      $display("roller_pattern_sequencer_with_deadtime test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/rps_pkg.sv
hdl/rps_core.sv
hdl/roller_pattern_sequencer_with_deadtime.sv
verif/testbench.sv
